// ===== rtl/core/fexo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fexo_pkg
// Shared types and command codes for the fusion read exon overlap check.
// ----------------------------------------------------------------------------
package fexo_pkg;

    localparam int CMD_W   = 2;
    localparam int CHROM_W = 8;
    localparam int COORD_W = 32;

    // Input item command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_FIRST  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_SECOND = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ       = 2'd3;

    // One interval: a stored exon or the read block under test
    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [COORD_W-1:0] start_pos;
        logic [COORD_W-1:0] end_pos;
    } interval_t;

endpackage

// ===== rtl/core/fusion_read_exon_overlap_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fusion_read_exon_overlap_check
// Flags reads whose blocks hit each of two candidate genes exclusively.
// ----------------------------------------------------------------------------
// Clear and append items never hold the input. A read block walks
// max(first table count, second table count) table entries, or none when
// both tables are empty: both exon tables sit in synchronous memories with
// one write and one read port that are walked together, one entry per cycle,
// followed by the memory read latency and the two-stage overlap compare.
// While a read block is being scanned no new item is accepted. A result
// waits in an output register, so a following item is taken while a result
// is still stalled; the scan of a last block holds at its end until the
// output register is free.
module fusion_read_exon_overlap_check #(
    parameter int EXON_DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [fexo_pkg::CMD_W-1:0]   command,
    input  logic [fexo_pkg::CHROM_W-1:0] chrom_id,
    input  logic [fexo_pkg::COORD_W-1:0] interval_start,
    input  logic [fexo_pkg::COORD_W-1:0] interval_end,
    input  logic                         last_block,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         is_fusion,
    output logic                         only_first_seen,
    output logic                         only_second_seen
);

    localparam int AW = (EXON_DEPTH > 1) ? $clog2(EXON_DEPTH) : 1;
    localparam int CW = $clog2(EXON_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       cnt1_reg, cnt1_next;
    logic [CW-1:0]       cnt2_reg, cnt2_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic [CW-1:0]       span_reg, span_next;
    logic                flag1_reg, flag1_next;
    logic                flag2_reg, flag2_next;
    logic                acc1_reg, acc1_next;
    logic                acc2_reg, acc2_next;
    logic                last_reg, last_next;
    logic [2:0]          pv_reg, pv_next;
    logic                ev1_reg, ev2_reg;
    logic                out_valid_reg, out_valid_next;
    logic                fus_reg, fus_next;
    logic                seen1_reg, seen1_next;
    logic                seen2_reg, seen2_next;
    fexo_pkg::interval_t probe_reg, probe_next;

    logic                accept;
    logic                issue;
    logic                out_free;
    logic                wr1_en, wr2_en;
    logic                hit1, hit2;
    logic                f1_upd, f2_upd;
    fexo_pkg::interval_t in_item;
    fexo_pkg::interval_t rd1_data, rd2_data;

    assign in_item.chrom     = chrom_id;
    assign in_item.start_pos = interval_start;
    assign in_item.end_pos   = interval_end;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign issue    = (state_reg == ST_SCAN);
    assign out_free = !out_valid_reg || !out_stall;

    // Append writes go to the next free entry of a table that is not full
    assign wr1_en = accept && (command == fexo_pkg::CMD_ADD_FIRST)
                    && (cnt1_reg < CW'(EXON_DEPTH));
    assign wr2_en = accept && (command == fexo_pkg::CMD_ADD_SECOND)
                    && (cnt2_reg < CW'(EXON_DEPTH));

    fexo_exon_mem #(
        .DEPTH (EXON_DEPTH),
        .AW    (AW)
    ) u_mem_first (
        .clk     (clk),
        .wr_en   (wr1_en),
        .wr_addr (cnt1_reg[AW-1:0]),
        .wr_data (in_item),
        .rd_en   (issue),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (rd1_data)
    );

    fexo_exon_mem #(
        .DEPTH (EXON_DEPTH),
        .AW    (AW)
    ) u_mem_second (
        .clk     (clk),
        .wr_en   (wr2_en),
        .wr_addr (cnt2_reg[AW-1:0]),
        .wr_data (in_item),
        .rd_en   (issue),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (rd2_data)
    );

    fexo_overlap u_ovl_first (
        .clk         (clk),
        .rst_n       (rst_n),
        .probe       (probe_reg),
        .entry       (rd1_data),
        .entry_valid (pv_reg[0] && ev1_reg),
        .hit         (hit1)
    );

    fexo_overlap u_ovl_second (
        .clk         (clk),
        .rst_n       (rst_n),
        .probe       (probe_reg),
        .entry       (rd2_data),
        .entry_valid (pv_reg[0] && ev2_reg),
        .hit         (hit2)
    );

    // Flags as they stand after this read block
    assign f1_upd = flag1_reg || (acc1_reg && !acc2_reg);
    assign f2_upd = flag2_reg || (acc2_reg && !acc1_reg);

    // Sequence commands, scan and result
    always_comb
    begin
        state_next     = state_reg;
        cnt1_next      = cnt1_reg;
        cnt2_next      = cnt2_reg;
        scan_next      = scan_reg;
        span_next      = span_reg;
        flag1_next     = flag1_reg;
        flag2_next     = flag2_reg;
        acc1_next      = acc1_reg || hit1;
        acc2_next      = acc2_reg || hit2;
        last_next      = last_reg;
        probe_next     = probe_reg;
        pv_next        = {pv_reg[1:0], issue};
        out_valid_next = out_valid_reg && out_stall;
        fus_next       = fus_reg;
        seen1_next     = seen1_reg;
        seen2_next     = seen2_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        fexo_pkg::CMD_CLEAR:
                        begin
                            cnt1_next  = '0;
                            cnt2_next  = '0;
                            flag1_next = 1'b0;
                            flag2_next = 1'b0;
                        end
                        fexo_pkg::CMD_ADD_FIRST:
                        begin
                            if (wr1_en)
                            begin
                                cnt1_next = CW'(cnt1_reg + 1'b1);
                            end
                        end
                        fexo_pkg::CMD_ADD_SECOND:
                        begin
                            if (wr2_en)
                            begin
                                cnt2_next = CW'(cnt2_reg + 1'b1);
                            end
                        end
                        fexo_pkg::CMD_READ:
                        begin
                            probe_next = in_item;
                            last_next  = last_block;
                            acc1_next  = 1'b0;
                            acc2_next  = 1'b0;
                            scan_next  = '0;
                            span_next  = (cnt1_reg > cnt2_reg) ? cnt1_reg : cnt2_reg;
                            // Skip the walk when both tables are empty
                            if ((cnt1_reg == '0) && (cnt2_reg == '0))
                            begin
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Advance one entry per cycle in both tables
                scan_next = CW'(scan_reg + 1'b1);
                if (CW'(scan_reg + 1'b1) == span_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // Wait for the compare pipe to empty, then fold in the hits
                if (pv_reg == 3'b000)
                begin
                    if (!last_reg)
                    begin
                        flag1_next = f1_upd;
                        flag2_next = f2_upd;
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        fus_next       = f1_upd && f2_upd;
                        seen1_next     = f1_upd;
                        seen2_next     = f2_upd;
                        flag1_next     = 1'b0;
                        flag2_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            flag1_reg     <= 1'b0;
            flag2_reg     <= 1'b0;
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt1_reg      <= cnt1_next;
            cnt2_reg      <= cnt2_next;
            flag1_reg     <= flag1_next;
            flag2_reg     <= flag2_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        span_reg  <= span_next;
        acc1_reg  <= acc1_next;
        acc2_reg  <= acc2_next;
        last_reg  <= last_next;
        probe_reg <= probe_next;
        ev1_reg   <= scan_reg < cnt1_reg;
        ev2_reg   <= scan_reg < cnt2_reg;
        fus_reg   <= fus_next;
        seen1_reg <= seen1_next;
        seen2_reg <= seen2_next;
    end

    assign out_valid        = out_valid_reg;
    assign is_fusion        = fus_reg;
    assign only_first_seen  = seen1_reg;
    assign only_second_seen = seen2_reg;

endmodule

// ===== rtl/core/fexo_exon_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fexo_exon_mem
// Exon table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fexo_exon_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  fexo_pkg::interval_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output fexo_pkg::interval_t rd_data
);

    fexo_pkg::interval_t mem [DEPTH];
    fexo_pkg::interval_t rd_data_reg;

    // Write an appended exon
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry per cycle during a scan
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/fexo_overlap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fexo_overlap
// Two-stage overlap test of the read block against one streamed table entry.
// ----------------------------------------------------------------------------
module fexo_overlap (
    input  logic                clk,
    input  logic                rst_n,
    input  fexo_pkg::interval_t probe,
    input  fexo_pkg::interval_t entry,
    input  logic                entry_valid,
    output logic                hit
);

    logic                         a_valid_reg;
    logic                         a_valid_next;
    logic                         a_chrom_eq_reg;
    logic                         a_chrom_eq_next;
    logic [fexo_pkg::COORD_W-1:0] a_lo_end_reg;
    logic [fexo_pkg::COORD_W-1:0] a_lo_end_next;
    logic [fexo_pkg::COORD_W-1:0] a_hi_start_reg;
    logic [fexo_pkg::COORD_W-1:0] a_hi_start_next;
    logic                         hit_reg;
    logic                         hit_next;

    // Stage A: pick the smaller end and the larger start
    always_comb
    begin
        a_valid_next    = entry_valid;
        a_chrom_eq_next = (probe.chrom == entry.chrom);
        a_lo_end_next   = (probe.end_pos < entry.end_pos) ? probe.end_pos : entry.end_pos;
        a_hi_start_next = (probe.start_pos > entry.start_pos) ? probe.start_pos
                                                              : entry.start_pos;
    end

    // Stage B: strict overlap test
    assign hit_next = a_valid_reg && a_chrom_eq_reg && (a_lo_end_reg > a_hi_start_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_chrom_eq_reg <= a_chrom_eq_next;
        a_lo_end_reg   <= a_lo_end_next;
        a_hi_start_reg <= a_hi_start_next;
    end

    assign hit = hit_reg;

endmodule

// ===== rtl/core/fexo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fexo_checker
// Port-level checks of the fusion read exon overlap check, bound to the top.
// ----------------------------------------------------------------------------
module fexo_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [fexo_pkg::CMD_W-1:0]   command,
    input logic [fexo_pkg::CHROM_W-1:0] chrom_id,
    input logic [fexo_pkg::COORD_W-1:0] interval_start,
    input logic [fexo_pkg::COORD_W-1:0] interval_end,
    input logic                         last_block,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         is_fusion,
    input logic                         only_first_seen,
    input logic                         only_second_seen
);

    // A result is fusion exactly when both exclusive hits were seen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_fusion == (only_first_seen && only_second_seen)))
        else $error("fusion bit disagrees with seen bits");

    // Clear and append items do not hold the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (command != fexo_pkg::CMD_READ)) |=> !in_stall)
        else $error("table command held the input");

    // A read block always holds the input, for its scan or its drain
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (command == fexo_pkg::CMD_READ)) |=> in_stall)
        else $error("read block did not start a scan");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(is_fusion) && $stable(only_first_seen)
             && $stable(only_second_seen)))
        else $error("stalled result changed");

endmodule

bind fusion_read_exon_overlap_check fexo_checker u_fexo_checker (.*);
